### rtl/twled_pkg.sv
// ============================================================================
// twled_pkg
// Shared types, codes and constants for the two-wire LED level display master.
// ============================================================================
package twled_pkg;

    // Request selector codes carried on the input tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_LEVEL = 2'd1;
    localparam logic [1:0] REQ_FRAME = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] CFG_FIXED_CMD  = 2'd1;
    localparam logic [1:0] CFG_AUTO_CMD   = 2'd2;

    // Configuration reset values
    localparam logic [2:0] BRIGHTNESS_RST = 3'd2;
    localparam logic [7:0] FIXED_CMD_RST  = 8'h44;
    localparam logic [7:0] AUTO_CMD_RST   = 8'h40;

    // Transaction numbers; zero means idle
    localparam logic [1:0] TXN_IDLE = 2'd0;
    localparam logic [1:0] TXN_CMD  = 2'd1;
    localparam logic [1:0] TXN_DATA = 2'd2;
    localparam logic [1:0] TXN_CTRL = 2'd3;

    // Bytes sent in the data transaction (address byte included)
    localparam logic [2:0] DATA_BYTES_LEVEL = 3'd2;
    localparam logic [2:0] DATA_BYTES_FRAME = 3'd4;
    localparam logic [2:0] ONE_BYTE         = 3'd1;

    // Fixed bytes on the wire
    localparam logic [7:0] DISP_CTRL_BASE = 8'h88;
    localparam logic [7:0] ADDR_LEVEL     = 8'hC0;
    localparam logic [7:0] ADDR_FRAME     = 8'hC1;
    localparam logic [7:0] FRAME_SEG_ON   = 8'h40;
    localparam logic [7:0] FRAME_SEG_OFF  = 8'h00;

    // Wire phase codes within a unit
    localparam logic [2:0] PH_0 = 3'd0;
    localparam logic [2:0] PH_1 = 3'd1;
    localparam logic [2:0] PH_2 = 3'd2;
    localparam logic [2:0] PH_3 = 3'd3;
    localparam logic [2:0] PH_4 = 3'd4;

    localparam logic [2:0] LAST_BIT = 3'd7;

    // Unit within a transaction
    typedef enum logic [1:0] {
        U_START = 2'd0,
        U_BITS  = 2'd1,
        U_ACK   = 2'd2,
        U_STOP  = 2'd3
    } unit_t;

    // Bar pattern for each level
    function automatic logic [7:0] level_pattern(input logic [2:0] lvl);
        logic [7:0] pat;
        unique case (lvl)
            3'd0:    pat = 8'h00;
            3'd1:    pat = 8'h40;
            3'd2:    pat = 8'h60;
            3'd3:    pat = 8'h70;
            3'd4:    pat = 8'h78;
            3'd5:    pat = 8'h7C;
            3'd6:    pat = 8'h7E;
            default: pat = 8'h7F;
        endcase
        return pat;
    endfunction

endpackage

### rtl/two_wire_led_level_display_master.sv
// ============================================================================
// two_wire_led_level_display_master
// Bit-level master for a two-wire LED bar driver; each tick item advances the
// wire by one phase step; a request at idle starts a three-transaction write.
// ============================================================================
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+----------
//  s_      | in  | level[2:0], frame_on, dio_in, 3'b0         | req_type
//  m_      | out | clk_level, dio_level, dio_drive, busy_res, | -
//          |     | done_res, ack_bit, request_dropped, 1'b0   |
//  cfg_    | in  | write enable, index, 8-bit data            | -
//
//  One item per cycle while results are taken: the wire state is updated and
//  the result register loaded on the same edge at which an item is accepted.
//  s_tready is high while the result register is empty or being taken, so a
//  stalled m_ side stalls the input with no item lost.
//  Synchronous active-low reset returns to idle with both lines high, driven.
//
module two_wire_led_level_display_master (
    input  logic       aclk,
    input  logic       aresetn,
    // input items
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // level[2:0], frame_on, dio_in, zero pad
    input  logic [1:0] s_tuser,   // req_type
    // result items
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // clk_level, dio_level, dio_drive, busy_res,
                                  // done_res, ack_bit, request_dropped, zero pad
    // configuration writes
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata
);
    import twled_pkg::*;

    // configuration
    logic [2:0] brightness_reg;
    logic [7:0] fixed_cmd_reg;
    logic [7:0] auto_cmd_reg;

    // wire sequencer state
    logic [1:0] txn_reg,        txn_next;
    unit_t      unit_reg,       unit_next;
    logic [2:0] phase_reg,      phase_next;
    logic [2:0] bit_cnt_reg,    bit_cnt_next;
    logic [7:0] shift_reg,      shift_next;
    logic [2:0] bytes_left_reg, bytes_left_next;
    logic       kind_reg,       kind_next;
    logic [2:0] held_level_reg, held_level_next;
    logic       held_frame_reg, held_frame_next;
    logic       ack_reg,        ack_next;
    logic       clk_reg,        clk_next;
    logic       dio_reg,        dio_next;
    logic       drv_reg,        drv_next;

    // result register
    logic       out_valid_reg;
    logic [6:0] out_reg;
    logic       done_next;
    logic       dropped_next;

    logic       accept;
    logic [2:0] in_level;
    logic       in_frame;
    logic       in_dio;
    logic       busy;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = ~out_valid_reg | m_tready;
    assign in_level = s_tdata[2:0];
    assign in_frame = s_tdata[3];
    assign in_dio   = s_tdata[4];
    assign busy     = (txn_reg != TXN_IDLE);

    // byte count of a transaction
    function automatic logic [2:0] txn_total(input logic [1:0] txn, input logic kind);
        logic [2:0] tot;
        if (txn == TXN_DATA) begin
            tot = kind ? DATA_BYTES_FRAME : DATA_BYTES_LEVEL;
        end else begin
            tot = ONE_BYTE;
        end
        return tot;
    endfunction

    // next byte to shift out for the current transaction
    logic [2:0] byte_idx;
    logic [7:0] load_byte;

    always_comb begin
        byte_idx = (bytes_left_reg <= txn_total(txn_reg, kind_reg))
                 ? txn_total(txn_reg, kind_reg) - bytes_left_reg : 3'd0;
        priority if (txn_reg == TXN_CMD) begin
            load_byte = kind_reg ? auto_cmd_reg : fixed_cmd_reg;
        end else if (txn_reg == TXN_DATA) begin
            priority if (byte_idx == 3'd0) begin
                load_byte = kind_reg ? ADDR_FRAME : ADDR_LEVEL;
            end else if (kind_reg) begin
                load_byte = held_frame_reg ? FRAME_SEG_ON : FRAME_SEG_OFF;
            end else begin
                load_byte = level_pattern(held_level_reg);
            end
        end else begin
            load_byte = DISP_CTRL_BASE + {5'd0, brightness_reg};
        end
    end

    // next state of the wire sequencer
    always_comb begin
        txn_next        = txn_reg;
        unit_next       = unit_reg;
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        kind_next       = kind_reg;
        held_level_next = held_level_reg;
        held_frame_next = held_frame_reg;
        ack_next        = ack_reg;
        clk_next        = clk_reg;
        dio_next        = dio_reg;
        drv_next        = drv_reg;
        done_next       = 1'b0;
        dropped_next    = 1'b0;

        if (s_tuser == REQ_LEVEL || s_tuser == REQ_FRAME) begin
            if (busy) begin
                dropped_next = 1'b1;
            end else begin
                // start condition of the command transaction
                kind_next       = (s_tuser == REQ_FRAME);
                held_level_next = in_level;
                held_frame_next = in_frame;
                txn_next        = TXN_CMD;
                unit_next       = U_START;
                phase_next      = PH_0;
                bytes_left_next = ONE_BYTE;
                dio_next        = 1'b0;
                drv_next        = 1'b1;
            end
        end else if (busy) begin
            unique case (unit_reg)
                U_START: begin
                    shift_next      = load_byte;
                    bytes_left_next = (bytes_left_reg != 3'd0) ? bytes_left_reg - 3'd1
                                                               : bytes_left_reg;
                    bit_cnt_next    = 3'd0;
                    phase_next      = PH_0;
                    unit_next       = U_BITS;
                    clk_next        = 1'b0;
                    drv_next        = 1'b1;
                end
                U_BITS: begin
                    unique case (phase_reg)
                        PH_0: begin
                            phase_next = PH_1;
                            clk_next   = 1'b0;
                            dio_next   = shift_reg[0];
                            drv_next   = 1'b1;
                        end
                        PH_1: begin
                            phase_next = PH_2;
                            clk_next   = 1'b1;
                            drv_next   = 1'b1;
                        end
                        default: begin
                            shift_next = {1'b0, shift_reg[7:1]};
                            phase_next = PH_0;
                            clk_next   = 1'b0;
                            drv_next   = 1'b1;
                            if (bit_cnt_reg >= LAST_BIT) begin
                                unit_next = U_ACK;
                                dio_next  = 1'b1;
                            end else begin
                                bit_cnt_next = bit_cnt_reg + 3'd1;
                            end
                        end
                    endcase
                end
                U_ACK: begin
                    unique case (phase_reg)
                        PH_0: begin
                            phase_next = PH_1;
                            clk_next   = 1'b1;
                            drv_next   = 1'b1;
                        end
                        PH_1: begin
                            // release data for the acknowledge
                            phase_next = PH_2;
                            drv_next   = 1'b0;
                        end
                        PH_2: begin
                            ack_next   = in_dio;
                            phase_next = PH_3;
                            drv_next   = 1'b1;
                        end
                        PH_3: begin
                            phase_next = PH_4;
                            clk_next   = 1'b0;
                            drv_next   = 1'b1;
                        end
                        default: begin
                            drv_next = 1'b1;
                            if (bytes_left_reg != 3'd0) begin
                                // next byte of the same transaction
                                shift_next      = load_byte;
                                bytes_left_next = bytes_left_reg - 3'd1;
                                bit_cnt_next    = 3'd0;
                                phase_next      = PH_0;
                                unit_next       = U_BITS;
                                clk_next        = 1'b0;
                            end else begin
                                unit_next  = U_STOP;
                                phase_next = PH_0;
                                dio_next   = 1'b0;
                            end
                        end
                    endcase
                end
                U_STOP: begin
                    drv_next = 1'b1;
                    priority if (phase_reg == PH_0) begin
                        phase_next = PH_1;
                        clk_next   = 1'b1;
                    end else if (phase_reg == PH_1) begin
                        phase_next = PH_2;
                        dio_next   = 1'b1;
                    end else if (txn_reg != TXN_CTRL) begin
                        // start of the following transaction
                        txn_next        = txn_reg + 2'd1;
                        unit_next       = U_START;
                        phase_next      = PH_0;
                        bytes_left_next = txn_total(txn_reg + 2'd1, kind_reg);
                        dio_next        = 1'b0;
                    end else begin
                        txn_next   = TXN_IDLE;
                        unit_next  = U_START;
                        phase_next = PH_0;
                        clk_next   = 1'b1;
                        dio_next   = 1'b1;
                        done_next  = 1'b1;
                    end
                end
                default: begin
                    unit_next = U_START;
                end
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txn_reg        <= TXN_IDLE;
            unit_reg       <= U_START;
            phase_reg      <= PH_0;
            bit_cnt_reg    <= 3'd0;
            shift_reg      <= 8'd0;
            bytes_left_reg <= 3'd0;
            kind_reg       <= 1'b0;
            held_level_reg <= 3'd0;
            held_frame_reg <= 1'b0;
            ack_reg        <= 1'b1;
            clk_reg        <= 1'b1;
            dio_reg        <= 1'b1;
            drv_reg        <= 1'b1;
        end else if (accept) begin
            txn_reg        <= txn_next;
            unit_reg       <= unit_next;
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            kind_reg       <= kind_next;
            held_level_reg <= held_level_next;
            held_frame_reg <= held_frame_next;
            ack_reg        <= ack_next;
            clk_reg        <= clk_next;
            dio_reg        <= dio_next;
            drv_reg        <= drv_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHTNESS_RST;
            fixed_cmd_reg  <= FIXED_CMD_RST;
            auto_cmd_reg   <= AUTO_CMD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_BRIGHTNESS: brightness_reg <= cfg_wdata[2:0];
                CFG_FIXED_CMD:  fixed_cmd_reg  <= cfg_wdata;
                CFG_AUTO_CMD:   auto_cmd_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= {dropped_next, ack_next, done_next, (txn_next != TXN_IDLE),
                        drv_next, dio_next, clk_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: two-wire LED level display master testbench
// Drives request and tick transfers on the input stream and predicts the wire
// levels and status flags that each one produces. Covers idle items, dropped
// requests, level and frame writes, and the acknowledge sampling. It also runs
// several register settings and a long output stall that back-pressures the
// input. Each result transfer is checked field by field against the oldest
// expected result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twled_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam logic [1:0] REQ_ALIAS_TICK = 2'd3;  // top selector code behaves as a tick

    localparam logic [7:0] BAR_PATTERNS [8] = '{
        8'h00, 8'h40, 8'h60, 8'h70, 8'h78, 8'h7C, 8'h7E, 8'h7F
    };

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_drive;
        logic busy;
        logic done;
        logic ack;
        logic dropped;
    } line_result_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;  // level[2:0], frame_on, dio_in, zero pad
    logic [1:0] s_tuser   = 2'd0;   // req_type
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // clk_level, dio_level, dio_drive, busy_res,
                                    // done_res, ack_bit, request_dropped, zero pad
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr  = 2'd0;
    logic [7:0] cfg_wdata = 8'h00;

    two_wire_led_level_display_master i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predicted register and wire state
    logic [2:0] cfg_brightness;
    logic [7:0] cfg_fixed_cmd;
    logic [7:0] cfg_auto_cmd;
    logic [1:0] p_txn;
    unit_t      p_unit;
    logic [2:0] p_phase;
    logic [2:0] p_bit_cnt;
    logic [7:0] p_shift;
    logic [2:0] p_bytes_left;
    logic       p_frame_kind;
    logic [2:0] p_level;
    logic       p_frame_on;
    logic       p_ack;
    logic       line_clk;
    logic       line_dio;
    logic       line_drv;

    line_result_t expected_lines[$];

    int  mismatches      = 0;
    int  items_sent      = 0;
    int  results_seen    = 0;
    int  writes_done     = 0;
    int  writes_dropped  = 0;
    int  acks_low        = 0;
    int  acks_high       = 0;
    int  burst_left      = 0;
    bit  sender_gaps     = 1'b1;
    int  holds_wanted    = 0;
    int  holds_served    = 0;
    int  hold_left       = 0;
    int  cycle_count     = 0;
    int  stall_mode      = 0;
    int  stall_mode_left = 0;
    logic [1:0] stall_tick = 2'd0;

    function automatic logic [2:0] txn_byte_count(input logic [1:0] txn);
        if (txn == TXN_DATA) begin
            return p_frame_kind ? DATA_BYTES_FRAME : DATA_BYTES_LEVEL;
        end
        return ONE_BYTE;
    endfunction

    // Pick the next byte of the current transaction and reset the bit counters
    function automatic void load_wire_byte();
        logic [2:0] total;
        logic [2:0] idx;
        total = txn_byte_count(p_txn);
        idx   = (p_bytes_left <= total) ? total - p_bytes_left : 3'd0;
        if (p_txn == TXN_CMD) begin
            p_shift = p_frame_kind ? cfg_auto_cmd : cfg_fixed_cmd;
        end else if (p_txn == TXN_DATA) begin
            if (idx == 3'd0) begin
                p_shift = p_frame_kind ? ADDR_FRAME : ADDR_LEVEL;
            end else if (p_frame_kind) begin
                p_shift = p_frame_on ? FRAME_SEG_ON : FRAME_SEG_OFF;
            end else begin
                p_shift = BAR_PATTERNS[p_level];
            end
        end else begin
            p_shift = DISP_CTRL_BASE + {5'b00000, cfg_brightness};
        end
        if (p_bytes_left != 3'd0) begin
            p_bytes_left = p_bytes_left - 3'd1;
        end
        p_bit_cnt = 3'd0;
        p_phase   = PH_0;
    endfunction

    // Start condition: data low, clock unchanged
    function automatic void open_txn(input logic [1:0] txn);
        p_txn        = txn;
        p_unit       = U_START;
        p_phase      = PH_0;
        p_bytes_left = txn_byte_count(txn);
        line_dio     = 1'b0;
        line_drv     = 1'b1;
    endfunction

    // One wire step of a busy master; returns 1 when the final stop ends
    function automatic logic advance_wire(input logic din);
        logic finished;
        finished = 1'b0;
        line_drv = 1'b1;
        case (p_unit)
            U_START: begin
                load_wire_byte();
                p_unit   = U_BITS;
                line_clk = 1'b0;
            end
            U_BITS: begin
                if (p_phase == PH_0) begin
                    p_phase  = PH_1;
                    line_clk = 1'b0;
                    line_dio = p_shift[0];
                end else if (p_phase == PH_1) begin
                    p_phase  = PH_2;
                    line_clk = 1'b1;
                end else begin
                    p_shift  = p_shift >> 1;
                    line_clk = 1'b0;
                    if (p_bit_cnt >= LAST_BIT) begin
                        p_unit   = U_ACK;
                        line_dio = 1'b1;
                    end else begin
                        p_bit_cnt = p_bit_cnt + 3'd1;
                    end
                    p_phase = PH_0;
                end
            end
            U_ACK: begin
                if (p_phase == PH_0) begin
                    p_phase  = PH_1;
                    line_clk = 1'b1;
                end else if (p_phase == PH_1) begin
                    p_phase  = PH_2;
                    line_drv = 1'b0;
                end else if (p_phase == PH_2) begin
                    // acknowledge sampled at the end of the released delay
                    p_ack   = din;
                    p_phase = PH_3;
                    if (din) acks_high++;
                    else acks_low++;
                end else if (p_phase == PH_3) begin
                    p_phase  = PH_4;
                    line_clk = 1'b0;
                end else if (p_bytes_left != 3'd0) begin
                    load_wire_byte();
                    p_unit   = U_BITS;
                    line_clk = 1'b0;
                end else begin
                    p_unit   = U_STOP;
                    p_phase  = PH_0;
                    line_dio = 1'b0;
                end
            end
            default: begin
                if (p_phase == PH_0) begin
                    p_phase  = PH_1;
                    line_clk = 1'b1;
                end else if (p_phase == PH_1) begin
                    p_phase  = PH_2;
                    line_dio = 1'b1;
                end else if (p_txn != TXN_CTRL) begin
                    open_txn(p_txn + 2'd1);
                end else begin
                    p_txn    = TXN_IDLE;
                    p_unit   = U_START;
                    p_phase  = PH_0;
                    line_clk = 1'b1;
                    line_dio = 1'b1;
                    finished = 1'b1;
                end
            end
        endcase
        return finished;
    endfunction

    // Expected result of one accepted input transfer
    function automatic line_result_t predict_wire_step(input logic [1:0] req,
                                                       input logic [2:0] lvl,
                                                       input logic fon,
                                                       input logic din);
        line_result_t r;
        logic was_busy;
        was_busy  = (p_txn != TXN_IDLE);
        r.done    = 1'b0;
        r.dropped = 1'b0;
        if (req == REQ_LEVEL || req == REQ_FRAME) begin
            if (was_busy) begin
                r.dropped = 1'b1;
                writes_dropped++;
            end else begin
                p_frame_kind = (req == REQ_FRAME);
                p_level      = lvl;
                p_frame_on   = fon;
                open_txn(TXN_CMD);
            end
        end else if (was_busy) begin
            r.done = advance_wire(din);
            if (r.done) writes_done++;
        end
        r.clk_level = line_clk;
        r.dio_level = line_dio;
        r.dio_drive = line_drv;
        r.busy      = (p_txn != TXN_IDLE);
        r.ack       = p_ack;
        return r;
    endfunction

    function automatic void reset_wire_model();
        cfg_brightness = BRIGHTNESS_RST;
        cfg_fixed_cmd  = FIXED_CMD_RST;
        cfg_auto_cmd   = AUTO_CMD_RST;
        p_txn          = TXN_IDLE;
        p_unit         = U_START;
        p_phase        = PH_0;
        p_bit_cnt      = 3'd0;
        p_shift        = 8'h00;
        p_bytes_left   = 3'd0;
        p_frame_kind   = 1'b0;
        p_level        = 3'd0;
        p_frame_on     = 1'b0;
        p_ack          = 1'b1;
        line_clk       = 1'b1;
        line_dio       = 1'b1;
        line_drv       = 1'b1;
    endfunction

    function automatic void compare_bit(input string field, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Send one item: bursts with random gaps, then wait for the transfer
    task automatic send_item(input logic [1:0] req, input logic [2:0] lvl,
                             input logic fon, input logic din);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, din, fon, lvl};
        do @(posedge aclk); while (!s_tready);
        expected_lines.push_back(predict_wire_step(req, lvl, fon, din));
        items_sent++;
    endtask

    function automatic logic [1:0] tick_code();
        return ($urandom_range(0, 4) == 0) ? REQ_ALIAS_TICK : REQ_TICK;
    endfunction

    // Ticks with random line samples until the running write is over
    task automatic finish_write();
        while (p_txn != TXN_IDLE) begin
            send_item(tick_code(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BRIGHTNESS: cfg_brightness = value[2:0];
            CFG_FIXED_CMD:  cfg_fixed_cmd  = value;
            CFG_AUTO_CMD:   cfg_auto_cmd   = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [7:0] bright, input logic [7:0] fixed_cmd,
                                 input logic [7:0] auto_cmd);
        drain_results();
        write_register(CFG_BRIGHTNESS, bright);
        write_register(CFG_FIXED_CMD, fixed_cmd);
        write_register(CFG_AUTO_CMD, auto_cmd);
    endtask

    // Mostly complete writes with random content, some noise and dropped requests
    task automatic run_traffic(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                send_item($urandom_range(0, 1) ? REQ_FRAME : REQ_LEVEL,
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            while (p_txn != TXN_IDLE) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_item($urandom_range(0, 1) ? REQ_FRAME : REQ_LEVEL,
                              3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_item(tick_code(), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // Ticks at idle leave the lines alone; the top selector code is a tick
    task automatic test_idle_items();
        send_item(REQ_TICK, 3'd7, 1'b1, 1'b1);
        send_item(REQ_ALIAS_TICK, 3'd0, 1'b0, 1'b0);
        send_item(REQ_TICK, 3'd0, 1'b0, 1'b0);
        send_item(REQ_ALIAS_TICK, 3'd7, 1'b1, 1'b1);
    endtask

    // Level write at both ends of the table, with requests dropped while busy
    task automatic test_level_write();
        send_item(REQ_LEVEL, 3'd7, 1'b0, 1'b0);
        send_item(REQ_FRAME, 3'd0, 1'b1, 1'b1);
        send_item(REQ_LEVEL, 3'd0, 1'b1, 1'b0);
        send_item(REQ_ALIAS_TICK, 3'd5, 1'b0, 1'b1);
        send_item(REQ_TICK, 3'd2, 1'b1, 1'b0);
        finish_write();
        send_item(REQ_LEVEL, 3'd0, 1'b1, 1'b1);
        finish_write();
    endtask

    task automatic test_frame_write();
        send_item(REQ_FRAME, 3'd3, 1'b1, 1'b0);
        send_item(REQ_LEVEL, 3'd4, 1'b0, 1'b1);
        finish_write();
        send_item(REQ_FRAME, 3'd6, 1'b0, 1'b1);
        finish_write();
    endtask

    // All registers at their lowest, then at their highest (upper bits set too)
    task automatic test_register_extremes();
        load_settings(8'h00, 8'h00, 8'h00);
        run_traffic(100);
        load_settings(8'hFF, 8'hFF, 8'hFF);
        run_traffic(100);
    endtask

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_output_stall();
        sender_gaps  = 1'b0;
        holds_wanted <= holds_wanted + 1;
        run_traffic(100);
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_settings();
        repeat (2) begin
            load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            run_traffic(100);
        end
    endtask

    // Receiver: random stall patterns, plus a long hold-off on request
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 2'd1;
        if (holds_served != holds_wanted) begin
            holds_served <= holds_wanted;
            hold_left    <= LONG_HOLD;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (stall_mode_left == 0) begin
                stall_mode      <= $urandom_range(0, 2);
                stall_mode_left <= $urandom_range(20, 120);
            end else begin
                stall_mode_left <= stall_mode_left - 1;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (stall_tick == 2'd0);
            endcase
        end
    end

    // Check each result transfer against the oldest expected result
    always @(posedge aclk) begin
        line_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_lines.size() == 0) begin
                $display("%0t: result transfer with none expected, actual %02h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_lines.pop_front();
                compare_bit("clk_level",       want.clk_level, m_tdata[0]);
                compare_bit("dio_level",       want.dio_level, m_tdata[1]);
                compare_bit("dio_drive",       want.dio_drive, m_tdata[2]);
                compare_bit("busy_res",        want.busy,      m_tdata[3]);
                compare_bit("done_res",        want.done,      m_tdata[4]);
                compare_bit("ack_bit",         want.ack,       m_tdata[5]);
                compare_bit("request_dropped", want.dropped,   m_tdata[6]);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_lines.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        reset_wire_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_items();
        test_level_write();
        test_frame_write();
        test_register_extremes();
        test_output_stall();
        test_random_settings();

        drain_results();
        repeat (8) @(posedge aclk);
        if (expected_lines.size() != 0) begin
            $display("%0d expected results never arrived", expected_lines.size());
            mismatches++;
        end
        $display("%0d input transfers, %0d results checked, %0d writes completed",
                 items_sent, results_seen, writes_done);
        $display("%0d requests dropped while busy, acknowledges sampled low %0d high %0d",
                 writes_dropped, acks_low, acks_high);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### two_wire_led_level_display_master.f
rtl/twled_pkg.sv
rtl/two_wire_led_level_display_master.sv
tb/sv/tb.sv
